FILE: rtl/pgr_pkg.sv
// ---------------------------------------------------------------------------
// pgr_pkg
// shared types and constants of the playback gain ramp stage
// ---------------------------------------------------------------------------
`default_nettype none

package pgr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int GAIN_BITS   = 17;
    localparam int COUNT_BITS  = 32;
    localparam int MAX_BLOCK   = 4096;
    localparam int BLOCK_BITS  = $clog2(MAX_BLOCK + 1);

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    localparam logic [GAIN_BITS-1:0]  UNITY_GAIN = GAIN_BITS'(65536);
    localparam logic [GAIN_BITS-1:0]  MIN_STEP   = GAIN_BITS'(1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [BLOCK_BITS-1:0] BLOCK_MAX  = BLOCK_BITS'(MAX_BLOCK);

    // register indexes
    localparam logic REG_TARGET_GAIN = 1'b0;
    localparam logic REG_GAIN_STEP   = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [GAIN_BITS-1:0]          gain_t;
    typedef logic [COUNT_BITS-1:0]         count_t;
    typedef logic [BLOCK_BITS-1:0]         block_cnt_t;

    // per-frame control flags
    typedef struct packed {
        logic present;
        logic ended;
        logic last;
        logic empty;
    } frame_flags_t;

    // statistics after a frame
    typedef struct packed {
        count_t underrun;
        count_t missing;
        count_t rendered;
        logic   done;
    } stats_t;

endpackage

`default_nettype wire

FILE: rtl/pgr_gain_ramp.sv
// ---------------------------------------------------------------------------
// pgr_gain_ramp
// running gain register, steps toward the target once per frame
// ---------------------------------------------------------------------------
`default_nettype none

module pgr_gain_ramp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pgr_pkg::gain_t target_gain,
    input  wire pgr_pkg::gain_t gain_step,
    input  wire logic          advance,
    output pgr_pkg::gain_t     gain_applied
);

    pgr_pkg::gain_t running_gain_reg;
    pgr_pkg::gain_t running_gain_next;
    pgr_pkg::gain_t tgt;
    pgr_pkg::gain_t step;
    pgr_pkg::gain_t diff;

    always_comb
    begin
        tgt  = (target_gain > pgr_pkg::UNITY_GAIN) ? pgr_pkg::UNITY_GAIN : target_gain;
        step = (gain_step == '0) ? pgr_pkg::MIN_STEP : gain_step;
        diff = '0;
        gain_applied = running_gain_reg;
        if (running_gain_reg < tgt)
        begin
            diff = tgt - running_gain_reg;
            gain_applied = (diff <= step) ? tgt : running_gain_reg + step;
        end
        else if (running_gain_reg > tgt)
        begin
            diff = running_gain_reg - tgt;
            gain_applied = (diff <= step) ? tgt : running_gain_reg - step;
        end
        running_gain_next = advance ? gain_applied : running_gain_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_gain_reg <= pgr_pkg::UNITY_GAIN;
        end
        else
        begin
            running_gain_reg <= running_gain_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pgr_scale.sv
// ---------------------------------------------------------------------------
// pgr_scale
// one sample times the q1.16 gain, floor shift by 16
// ---------------------------------------------------------------------------
`default_nettype none

module pgr_scale (
    input  wire pgr_pkg::sample_t sample,
    input  wire logic             present,
    input  wire pgr_pkg::gain_t   gain,
    output pgr_pkg::sample_t      scaled
);

    localparam int PROD_BITS = pgr_pkg::SAMPLE_BITS + pgr_pkg::GAIN_BITS + 1;

    logic signed [PROD_BITS-1:0] product;

    always_comb
    begin
        product = PROD_BITS'(sample * $signed({1'b0, gain}));
        // arithmetic shift keeps floor rounding
        scaled  = present ? product[pgr_pkg::SAMPLE_BITS+15:16] : '0;
    end

endmodule

`default_nettype wire

FILE: rtl/pgr_stats.sv
// ---------------------------------------------------------------------------
// pgr_stats
// block missing count, saturating totals and the sticky done flag
// ---------------------------------------------------------------------------
`default_nettype none

module pgr_stats (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pgr_pkg::frame_flags_t flags,
    input  wire logic                  advance,
    output pgr_pkg::stats_t            stats_after
);

    pgr_pkg::block_cnt_t block_missing_reg;
    pgr_pkg::block_cnt_t block_missing_next;
    pgr_pkg::stats_t     stats_reg;
    pgr_pkg::block_cnt_t bm_frame;
    logic [pgr_pkg::COUNT_BITS:0] miss_sum;

    always_comb
    begin
        bm_frame = block_missing_reg;
        if (!flags.present && (block_missing_reg < pgr_pkg::BLOCK_MAX))
        begin
            bm_frame = block_missing_reg + 1'b1;
        end

        miss_sum = {1'b0, stats_reg.missing}
                 + (pgr_pkg::COUNT_BITS + 1)'(bm_frame);

        stats_after = stats_reg;
        stats_after.rendered = (stats_reg.rendered == pgr_pkg::COUNT_MAX)
                             ? pgr_pkg::COUNT_MAX : stats_reg.rendered + 1'b1;
        block_missing_next = bm_frame;

        if (flags.last)
        begin
            if ((bm_frame != '0) && !flags.ended)
            begin
                stats_after.underrun = (stats_reg.underrun == pgr_pkg::COUNT_MAX)
                                     ? pgr_pkg::COUNT_MAX : stats_reg.underrun + 1'b1;
                stats_after.missing  = miss_sum[pgr_pkg::COUNT_BITS]
                                     ? pgr_pkg::COUNT_MAX
                                     : miss_sum[pgr_pkg::COUNT_BITS-1:0];
            end
            block_missing_next = '0;
            if (flags.ended && flags.empty)
            begin
                stats_after.done = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_missing_reg <= '0;
            stats_reg         <= '0;
        end
        else if (advance)
        begin
            block_missing_reg <= block_missing_next;
            stats_reg         <= stats_after;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/playback_gain_ramp_stage.sv
// ---------------------------------------------------------------------------
// playback_gain_ramp_stage
// player output stage: gain ramp, sample scaling and underrun statistics
// ---------------------------------------------------------------------------
// One stereo frame per beat. A beat taken on the input lands in an input
// register; when the result register is free, the running gain steps toward
// target_gain (clamped there), both samples are multiplied by it with a floor
// shift of 16, the counters update, and all of it is captured in the result
// register. The sustained rate is one frame per cycle while out_stall stays
// low, set by the single gain step plus 16x17 multiply between the two
// registers. The input keeps accepting while a result waits: in_stall
// rises only when both registers are full and out_stall is high.
// Missing frames (frame_present low) come out as silence but still step the
// gain and count as rendered. Registers: target_gain at address 0, gain_step
// at address 4, both 17 bits; write them only while the stage is empty.
// ---------------------------------------------------------------------------
`default_nettype none

module playback_gain_ramp_stage (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    // apb configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [pgr_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  wire logic [pgr_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic      [pgr_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                      pready,

    // input frame channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire pgr_pkg::sample_t                     sample_ch0,
    input  wire pgr_pkg::sample_t                     sample_ch1,
    input  wire logic                                 frame_present,
    input  wire logic                                 source_ended,
    input  wire logic                                 block_last,
    input  wire logic                                 buffer_empty,

    // result channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output pgr_pkg::sample_t                          out_ch0,
    output pgr_pkg::sample_t                          out_ch1,
    output pgr_pkg::gain_t                            gain_now,
    output pgr_pkg::count_t                           underrun_total,
    output pgr_pkg::count_t                           missing_total,
    output pgr_pkg::count_t                           rendered_total,
    output logic                                      playback_done
);

    // config registers
    pgr_pkg::gain_t target_gain_reg;
    pgr_pkg::gain_t gain_step_reg;
    logic           cfg_write;

    // input register
    logic                  in_valid_reg;
    pgr_pkg::sample_t      in_ch0_reg;
    pgr_pkg::sample_t      in_ch1_reg;
    pgr_pkg::frame_flags_t in_flags_reg;

    // result register
    logic             out_valid_reg;
    pgr_pkg::sample_t out_ch0_reg;
    pgr_pkg::sample_t out_ch1_reg;
    pgr_pkg::gain_t   gain_now_reg;
    pgr_pkg::stats_t  stats_out_reg;

    // datapath between the registers
    logic             out_free;
    logic             advance;
    logic             in_take;
    pgr_pkg::gain_t   gain_applied;
    pgr_pkg::sample_t scaled_ch0;
    pgr_pkg::sample_t scaled_ch1;
    pgr_pkg::stats_t  stats_after;

    // ------------------------------------------------------------------
    // apb: always ready, byte address picks the register
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            pgr_pkg::REG_TARGET_GAIN:
                prdata = pgr_pkg::APB_DATA_BITS'(target_gain_reg);
            pgr_pkg::REG_GAIN_STEP:
                prdata = pgr_pkg::APB_DATA_BITS'(gain_step_reg);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_gain_reg <= pgr_pkg::UNITY_GAIN;
            gain_step_reg   <= pgr_pkg::UNITY_GAIN;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                pgr_pkg::REG_TARGET_GAIN:
                    target_gain_reg <= pwdata[pgr_pkg::GAIN_BITS-1:0];
                pgr_pkg::REG_GAIN_STEP:
                    gain_step_reg   <= pwdata[pgr_pkg::GAIN_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: result register frees when empty or its beat is taken,
    // the frame in the input register moves whenever the result is free
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_ch0_reg   <= sample_ch0;
            in_ch1_reg   <= sample_ch1;
            in_flags_reg <= '{present: frame_present, ended: source_ended,
                              last: block_last, empty: buffer_empty};
        end
    end

    // ------------------------------------------------------------------
    // per-frame work
    // ------------------------------------------------------------------
    pgr_gain_ramp u_ramp (
        .clk          (clk),
        .rst_n        (rst_n),
        .target_gain  (target_gain_reg),
        .gain_step    (gain_step_reg),
        .advance      (advance),
        .gain_applied (gain_applied)
    );

    pgr_scale u_scale_ch0 (
        .sample  (in_ch0_reg),
        .present (in_flags_reg.present),
        .gain    (gain_applied),
        .scaled  (scaled_ch0)
    );

    pgr_scale u_scale_ch1 (
        .sample  (in_ch1_reg),
        .present (in_flags_reg.present),
        .gain    (gain_applied),
        .scaled  (scaled_ch1)
    );

    pgr_stats u_stats (
        .clk         (clk),
        .rst_n       (rst_n),
        .flags       (in_flags_reg),
        .advance     (advance),
        .stats_after (stats_after)
    );

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_ch0_reg   <= scaled_ch0;
            out_ch1_reg   <= scaled_ch1;
            gain_now_reg  <= gain_applied;
            stats_out_reg <= stats_after;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_ch0        = out_ch0_reg;
    assign out_ch1        = out_ch1_reg;
    assign gain_now       = gain_now_reg;
    assign underrun_total = stats_out_reg.underrun;
    assign missing_total  = stats_out_reg.missing;
    assign rendered_total = stats_out_reg.rendered;
    assign playback_done  = stats_out_reg.done;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the playback gain ramp stage
// ---------------------------------------------------------------------------
// Frames go in on the valid/stall input channel, and each result beat is
// compared field by field with a frame predictor kept in step with every
// accepted input beat. Directed tests cover unity passthrough, silence for
// missing frames, the gain ramp corner cases and source end handling. They
// are followed by random render blocks under several gain settings, with
// random gaps on the input side and random stall on the result side.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    // expected content of one result beat
    typedef struct {
        pgr_pkg::sample_t ch0;
        pgr_pkg::sample_t ch1;
        pgr_pkg::gain_t   gain;
        pgr_pkg::stats_t  stats;
    } frame_result_t;

    logic                                  clk;
    logic                                  rst_n;

    logic                                  psel;
    logic                                  penable;
    logic                                  pwrite;
    logic [pgr_pkg::APB_ADDR_BITS-1:0]     paddr;
    logic [pgr_pkg::APB_DATA_BITS-1:0]     pwdata;
    logic [pgr_pkg::APB_DATA_BITS-1:0]     prdata;
    logic                                  pready;

    logic                                  in_valid;
    logic                                  in_stall;
    pgr_pkg::sample_t                      sample_ch0;
    pgr_pkg::sample_t                      sample_ch1;
    logic                                  frame_present;
    logic                                  source_ended;
    logic                                  block_last;
    logic                                  buffer_empty;

    logic                                  out_valid;
    logic                                  out_stall;
    pgr_pkg::sample_t                      out_ch0;
    pgr_pkg::sample_t                      out_ch1;
    pgr_pkg::gain_t                        gain_now;
    pgr_pkg::count_t                       underrun_total;
    pgr_pkg::count_t                       missing_total;
    pgr_pkg::count_t                       rendered_total;
    logic                                  playback_done;

    // predictor copy of the registers and the running state
    pgr_pkg::gain_t                        level_target    = pgr_pkg::UNITY_GAIN;
    pgr_pkg::gain_t                        ramp_step       = pgr_pkg::UNITY_GAIN;
    pgr_pkg::gain_t                        ramp_gain       = pgr_pkg::UNITY_GAIN;
    pgr_pkg::block_cnt_t                   blk_missing     = '0;
    pgr_pkg::count_t                       underruns       = '0;
    pgr_pkg::count_t                       missed_frames   = '0;
    pgr_pkg::count_t                       rendered_frames = '0;
    logic                                  drained_flag    = 1'b0;

    // expected result beats, oldest first
    frame_result_t                         expected_frames[$];
    int                                    fail_count      = 0;

    // pacing knobs for the input gaps and the result stall
    bit                                    sender_paced    = 1'b1;
    bit                                    sink_paced      = 1'b1;
    // source state carried from one random block to the next
    bit                                    src_over        = 1'b0;

    playback_gain_ramp_stage u_dut (.*);

    // -----------------------------------------------------------------------
    // clock, watchdog
    // -----------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous against the slowest legal run: long gaps and long stalls on
    // every paced beat
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // -----------------------------------------------------------------------
    // frame predictor
    // -----------------------------------------------------------------------
    function automatic pgr_pkg::count_t sat_add(input pgr_pkg::count_t a,
                                                input pgr_pkg::count_t b);
        logic [pgr_pkg::COUNT_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[pgr_pkg::COUNT_BITS] ? pgr_pkg::COUNT_MAX : sum[pgr_pkg::COUNT_BITS-1:0];
    endfunction

    // multiply by a Q1.16 gain, arithmetic shift gives the floor
    function automatic pgr_pkg::sample_t scale_sample(input pgr_pkg::sample_t s,
                                                      input pgr_pkg::gain_t g);
        longint prod;
        prod = longint'(s) * longint'(g);
        return pgr_pkg::sample_t'(prod >>> 16);
    endfunction

    function automatic frame_result_t predict_frame(input pgr_pkg::sample_t a,
                                                    input pgr_pkg::sample_t b,
                                                    input pgr_pkg::frame_flags_t f);
        frame_result_t  r;
        pgr_pkg::gain_t goal;
        pgr_pkg::gain_t stp;
        // target above unity acts as unity, a zero step acts as one
        goal = (level_target > pgr_pkg::UNITY_GAIN) ? pgr_pkg::UNITY_GAIN : level_target;
        stp  = (ramp_step == '0) ? pgr_pkg::MIN_STEP : ramp_step;
        // step toward the target, landing exactly on it when close enough
        if (ramp_gain < goal)
            ramp_gain = (goal - ramp_gain <= stp) ? goal
                                                  : pgr_pkg::gain_t'(ramp_gain + stp);
        else if (ramp_gain > goal)
            ramp_gain = (ramp_gain - goal <= stp) ? goal
                                                  : pgr_pkg::gain_t'(ramp_gain - stp);

        if (f.present)
        begin
            r.ch0 = scale_sample(a, ramp_gain);
            r.ch1 = scale_sample(b, ramp_gain);
        end
        else
        begin
            // silence, and one more missing frame in this block
            r.ch0 = '0;
            r.ch1 = '0;
            if (blk_missing < pgr_pkg::BLOCK_MAX)
                blk_missing = blk_missing + 1'b1;
        end

        rendered_frames = sat_add(rendered_frames, pgr_pkg::count_t'(1));

        if (f.last)
        begin
            // missing frames after source end are dropped uncounted
            if (blk_missing != '0 && !f.ended)
            begin
                underruns     = sat_add(underruns, pgr_pkg::count_t'(1));
                missed_frames = sat_add(missed_frames, pgr_pkg::count_t'(blk_missing));
            end
            blk_missing = '0;
            if (f.ended && f.empty)
                drained_flag = 1'b1;
        end

        r.gain           = ramp_gain;
        r.stats.underrun = underruns;
        r.stats.missing  = missed_frames;
        r.stats.rendered = rendered_frames;
        r.stats.done     = drained_flag;
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // result checker
    // -----------------------------------------------------------------------
    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_frames.size() == 0)
            begin
                $display("%0t: result beat with none expected, actual ch0 %0d ch1 %0d gain %0d",
                         $time, out_ch0, out_ch1, gain_now);
                fail_count++;
            end
            else
            begin
                want = expected_frames.pop_front();
                compare_field("out_ch0", want.ch0, out_ch0);
                compare_field("out_ch1", want.ch1, out_ch1);
                compare_field("gain_now", want.gain, gain_now);
                compare_field("underrun_total", want.stats.underrun, underrun_total);
                compare_field("missing_total", want.stats.missing, missing_total);
                compare_field("rendered_total", want.stats.rendered, rendered_total);
                compare_field("playback_done", want.stats.done, playback_done);
            end
        end
    end

    // -----------------------------------------------------------------------
    // result side stall: mostly short bursts, now and then a long one
    // -----------------------------------------------------------------------
    initial
    begin
        int hold;
        int r;
        out_stall = 1'b0;
        hold      = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (!sink_paced)
                out_stall <= 1'b0;
            else if (out_stall)
            begin
                out_stall <= 1'b0;
                hold = $urandom_range(0, 6);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                begin
                    out_stall <= 1'b1;
                    hold = (r < 4) ? $urandom_range(8, 40) : $urandom_range(0, 2);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // stimulus helpers
    // -----------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (!sender_paced)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic pgr_pkg::sample_t rand_sample();
        case ($urandom_range(0, 19))
            0:       return {1'b1, {(pgr_pkg::SAMPLE_BITS-1){1'b0}}};
            1:       return {1'b0, {(pgr_pkg::SAMPLE_BITS-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return pgr_pkg::sample_t'($urandom);
        endcase
    endfunction

    // one input beat: optional gap, then hold the frame until it is taken
    task automatic send_frame(input pgr_pkg::sample_t a, input pgr_pkg::sample_t b,
                              input logic present, input logic ended, input logic last,
                              input logic empty);
        int                    gap;
        pgr_pkg::frame_flags_t f;
        gap = pick_gap();
        f.present = present;
        f.ended   = ended;
        f.last    = last;
        f.empty   = empty;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        sample_ch0    <= a;
        sample_ch1    <= b;
        frame_present <= present;
        source_ended  <= ended;
        block_last    <= last;
        buffer_empty  <= empty;
        do
            @(posedge clk);
        while (in_stall);
        expected_frames.push_back(predict_frame(a, b, f));
    endtask

    // stop sending and let every expected beat come back
    task automatic wait_empty();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        // input register and result register pipe, with margin on top
        repeat (4) @(posedge clk);
    endtask

    // register write followed by a read back, only with the stage empty
    task automatic write_reg(input logic idx,
                             input logic [pgr_pkg::APB_DATA_BITS-1:0] value);
        wait_empty();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        compare_field("prdata",
                      {{(pgr_pkg::APB_DATA_BITS-pgr_pkg::GAIN_BITS){1'b0}},
                       value[pgr_pkg::GAIN_BITS-1:0]},
                      prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == pgr_pkg::REG_TARGET_GAIN)
            level_target = value[pgr_pkg::GAIN_BITS-1:0];
        else
            ramp_step = value[pgr_pkg::GAIN_BITS-1:0];
    endtask

    // one render block of random content; now and then a broken one with no
    // closing frame, and the source state flips every few blocks
    task automatic random_block(inout int sent);
        int   len;
        bit   miss_heavy;
        logic present;
        logic ended;
        logic last;
        int   i;
        len        = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 12);
        miss_heavy = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 11) == 0)
            src_over = ~src_over;
        for (i = 0; i < len; i++)
        begin
            present = miss_heavy ? ($urandom_range(0, 99) >= 40) : ($urandom_range(0, 49) != 0);
            ended   = ($urandom_range(0, 29) == 0) ? ~src_over : src_over;
            last    = (i == len - 1) && ($urandom_range(0, 9) != 0);
            send_frame(rand_sample(), rand_sample(), present, ended, last,
                       logic'($urandom_range(0, 1)));
            sent++;
        end
    endtask

    task automatic random_phase(input logic [pgr_pkg::APB_DATA_BITS-1:0] target,
                                input logic [pgr_pkg::APB_DATA_BITS-1:0] step,
                                input bit paced, input int frames);
        int sent;
        write_reg(pgr_pkg::REG_TARGET_GAIN, target);
        write_reg(pgr_pkg::REG_GAIN_STEP, step);
        sender_paced = paced;
        sink_paced   = paced;
        sent         = 0;
        while (sent < frames)
            random_block(sent);
    endtask

    // -----------------------------------------------------------------------
    // tests
    // -----------------------------------------------------------------------

    // reset gain is unity, so samples pass through untouched
    task automatic test_unity_passthrough();
        send_frame(16'sh7FFF, 16'sh8000, 1'b1, 1'b0, 1'b0, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 1'b0, 1'b1);
        send_frame(16'sh0000, -16'sd1, 1'b1, 1'b0, 1'b0, 1'b0);
        // block closes with nothing missing: no underrun
        send_frame(16'sd1, -16'sd1, 1'b1, 1'b0, 1'b1, 1'b0);
    endtask

    // missing frames play silence and are counted at the block end
    task automatic test_missing_frames();
        send_frame(16'sh1234, 16'shEDCB, 1'b0, 1'b0, 1'b0, 1'b0);
        send_frame(16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 1'b0, 1'b0);
        // empty buffer but source still running: underrun, no done
        send_frame(16'sh0100, 16'sh0200, 1'b1, 1'b0, 1'b1, 1'b1);
        send_frame(16'sh0001, 16'sh0002, 1'b1, 1'b0, 1'b1, 1'b0);
        send_frame(16'sh4000, 16'shC000, 1'b0, 1'b0, 1'b0, 1'b0);
        // a missing frame earlier in the block still counts
        send_frame(16'sh2000, 16'shE000, 1'b1, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_gain_ramp();
        // zero step acts as one: slow ramp down, floor on negative samples
        write_reg(pgr_pkg::REG_TARGET_GAIN, 32'd0);
        write_reg(pgr_pkg::REG_GAIN_STEP, 32'd0);
        send_frame(-16'sd1, 16'sd1, 1'b1, 1'b0, 1'b0, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 1'b0, 1'b0);
        // full step jumps straight to the target
        write_reg(pgr_pkg::REG_GAIN_STEP, 32'h0001_0000);
        send_frame(16'sd12345, -16'sd12345, 1'b1, 1'b0, 1'b0, 1'b0);
        // target above unity acts as unity; the second step lands exactly on it
        write_reg(pgr_pkg::REG_TARGET_GAIN, 32'h0001_FFFF);
        write_reg(pgr_pkg::REG_GAIN_STEP, 32'd40000);
        send_frame(16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 1'b0, 1'b0);
        send_frame(-16'sd3, 16'sd3, 1'b1, 1'b0, 1'b0, 1'b0);
        send_frame(16'sh7FFF, 16'sh8000, 1'b1, 1'b0, 1'b0, 1'b0);
        // step wider than the distance, fractional gain with rounding toward minus infinity
        write_reg(pgr_pkg::REG_TARGET_GAIN, 32'd30000);
        write_reg(pgr_pkg::REG_GAIN_STEP, 32'h0001_FFFF);
        send_frame(-16'sd3, 16'sh8000, 1'b1, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_source_end();
        // buffer_empty away from the block end is ignored
        send_frame(16'sh5555, 16'shAAAA, 1'b0, 1'b1, 1'b0, 1'b1);
        // block ends after source end: missing count dropped, buffer not yet empty
        send_frame(16'sh0F0F, 16'shF0F0, 1'b1, 1'b1, 1'b1, 1'b0);
        // source ended and buffer drained: done
        send_frame(16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 1'b1, 1'b1);
        // done stays set
        send_frame(16'sh0001, 16'shFFFF, 1'b1, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic();
        random_phase(32'h0001_0000, 32'h0001_0000, 1'b1, 100);
        // unpaced stretch while the gain creeps down one step per frame
        random_phase(32'd0, 32'd1, 1'b0, 100);
        random_phase(32'd32768, 32'd1024, 1'b1, 100);
        // upper register bits are dropped on write
        random_phase($urandom, $urandom, 1'b1, 100);
        random_phase(32'h0001_0000, 32'd300, 1'b1, 100);
    endtask

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        sample_ch0    = '0;
        sample_ch1    = '0;
        frame_present = 1'b0;
        source_ended  = 1'b0;
        block_last    = 1'b0;
        buffer_empty  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_unity_passthrough();
        test_missing_frames();
        test_gain_ramp();
        test_source_end();
        test_random_traffic();

        wait_empty();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
